FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the histogram RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

FILE: hw/rtl/ppdh_pkg.sv
package ppdh_pkg;
    localparam int BINS_DEF = 256;
    localparam int CW = 24;
    localparam int LW = 23;
    localparam int HW = 40;
    localparam int PW = 48;
    localparam int WW = 16;

    localparam logic [1:0] CMD_ACC   = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    localparam logic [1:0] REG_MIN   = 2'd0;
    localparam logic [1:0] REG_MAX   = 2'd1;
    localparam logic [1:0] REG_WIDTH = 2'd2;
    localparam logic [1:0] REG_BINS  = 2'd3;

    typedef enum logic [1:0] {
        OP_DIV,
        OP_SQRT
    } t_op;

    typedef struct packed {
        logic        start;
        t_op         op;
        logic [63:0] num;
        logic [63:0] den;
    } t_unit_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
        logic [63:0] rem;
    } t_unit_rsp;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CLR,
        S_DX,
        S_DXW,
        S_DY,
        S_DYW,
        S_SQX,
        S_SQY,
        S_CMP,
        S_SQ,
        S_SQW,
        S_BIN,
        S_BINW,
        S_RD,
        S_UPD,
        S_OUT
    } t_state;
endpackage

FILE: hw/rtl/ppdh_if.sv
interface ppdh_in_if;
    logic                   valid;
    logic                   ready;
    logic [1:0]             command;
    logic                   upper_leaflet;
    logic                   same_group;
    logic signed [23:0]     first_x;
    logic signed [23:0]     first_y;
    logic signed [23:0]     second_x;
    logic signed [23:0]     second_y;
    logic [22:0]            box_x;
    logic [22:0]            box_y;
    logic [15:0]            weight;
    logic [7:0]             bin_index;
    modport source (output valid, command, upper_leaflet, same_group, first_x, first_y,
        second_x, second_y, box_x, box_y, weight, bin_index, input ready);
    modport sink (input valid, command, upper_leaflet, same_group, first_x, first_y,
        second_x, second_y, box_x, box_y, weight, bin_index, output ready);
endinterface

interface ppdh_out_if;
    logic        valid;
    logic        ready;
    logic        in_range;
    logic [7:0]  bin_hit;
    logic [39:0] upper_count;
    logic [39:0] lower_count;
    logic [47:0] upper_pairs;
    logic [47:0] lower_pairs;
    modport source (output valid, in_range, bin_hit, upper_count, lower_count,
        upper_pairs, lower_pairs, input ready);
    modport sink (input valid, in_range, bin_hit, upper_count, lower_count,
        upper_pairs, lower_pairs, output ready);
endinterface

interface ppdh_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [22:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/ppdh_unit.sv
// Shared iterative unit: one quotient bit or one root bit per cycle.
module ppdh_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ppdh_pkg::t_unit_req  i_req,
    output ppdh_pkg::t_unit_rsp  o_rsp
);
    import ppdh_pkg::*;
    `include "assert_macros.svh"

    logic        r_busy, n_busy;
    t_op         r_op, n_op;
    logic [6:0]  r_cnt, n_cnt;
    logic [63:0] r_q, n_q;
    logic [63:0] r_rem, n_rem;
    logic [63:0] r_den, n_den;
    logic [63:0] r_num, n_num;
    logic [64:0] div_try;
    logic [63:0] sq_bit, sq_try;
    logic        done;

    always_comb begin
        n_busy = r_busy;
        n_op = r_op;
        n_cnt = r_cnt;
        n_q = r_q;
        n_rem = r_rem;
        n_den = r_den;
        n_num = r_num;
        done = 1'b0;
        div_try = '0;
        sq_bit = '0;
        sq_try = '0;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_op = i_req.op;
            n_num = i_req.num;
            n_den = i_req.den;
            n_q = '0;
            n_rem = '0;
            n_cnt = (i_req.op == OP_DIV) ? 7'd64 : 7'd32;
        end else if (r_busy) begin
            if (r_op == OP_DIV) begin
                div_try = {r_rem, r_num[63]};
                n_num = {r_num[62:0], 1'b0};
                if (div_try >= {1'b0, r_den}) begin
                    n_rem = 64'(div_try - {1'b0, r_den});
                    n_q = {r_q[62:0], 1'b1};
                end else begin
                    n_rem = div_try[63:0];
                    n_q = {r_q[62:0], 1'b0};
                end
            end else begin
                sq_bit = 64'd1 << {r_cnt[5:0] - 6'd1, 1'b0};
                sq_try = r_q + sq_bit;
                if (r_num >= sq_try) begin
                    n_num = r_num - sq_try;
                    n_q = (r_q >> 1) + sq_bit;
                end else begin
                    n_q = r_q >> 1;
                end
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt <= n_cnt;
        end
        r_op <= n_op;
        r_q <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
        r_num <= n_num;
    end

    assign o_rsp.done = done;
    assign o_rsp.quo = n_q;
    assign o_rsp.rem = n_rem;

    `ASSERT_IMPLIES(a_done_busy, i_clk, i_rst_n, o_rsp.done, r_busy)
    `ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_req.start, r_busy)
    `ASSERT_IMPLIES(a_cnt_live, i_clk, i_rst_n, r_busy, r_cnt != 7'd0)
endmodule

FILE: hw/rtl/periodic_pair_distance_histogram_unit.sv
// Channel | Dir | Beat contents
// in      | in  | command, leaflet, self flag, two points, box, weight, bin index
// out     | out | in_range, bin, two bin counts, two pair totals
// cfg     | in  | register index and 23-bit value
// An in-range accumulate uses two 64-step wrap divisions, a 32-step root and a 64-step bin
// division on one shared iterative unit. A zero box length skips that axis's division, a zero
// bin width the bin division; an out-of-range pair skips root and bin. A read reads the
// banks before its result, a self pair or unknown command goes straight to it, and a
// clear offers it once all BINS entries are zeroed. After reset a clearing pass over all
// BINS entries runs before the first beat. A stalled result holds the block until it is taken.
module periodic_pair_distance_histogram_unit #(
    parameter int BINS = ppdh_pkg::BINS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ppdh_in_if.sink    i_in,
    ppdh_out_if.source o_out,
    ppdh_cfg_if.sink   i_cfg
);
    import ppdh_pkg::*;
    `include "assert_macros.svh"

    localparam int AW = (BINS > 1) ? $clog2(BINS) : 1;
    localparam logic [39:0] HMAX = '1;
    localparam logic [47:0] PMAX = '1;

    logic [HW-1:0] mem_u [BINS];
    logic [HW-1:0] mem_l [BINS];

    t_state r_st, n_st;
    logic [22:0] r_min, r_max, r_wid;
    logic [8:0]  r_nb;
    logic [PW-1:0] r_up, r_lp, n_up, n_lp;
    logic [AW:0] r_clr, n_clr;
    logic [1:0]  r_cmd;
    logic        r_upper;
    logic signed [24:0] r_dx, r_dy;
    logic [22:0] r_bx, r_by;
    logic [15:0] r_w;
    logic [48:0] r_d2, n_d2;
    logic [24:0] r_ax, n_ax;
    logic        r_rin, n_rin;
    logic [7:0]  r_bin, n_bin;
    logic [39:0] r_uc, r_lc;
    logic [39:0] r_mu, r_ml;
    logic        r_ov, n_ov;
    logic signed [24:0] n_dx, n_dy;

    t_unit_req req;
    t_unit_rsp rsp;

    ppdh_unit u_unit (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req), .o_rsp(rsp));

    logic signed [26:0] wnum;
    logic [25:0] wden;
    logic [63:0] wnum_off;
    logic signed [26:0] wq;
    logic [8:0] nbc;
    logic [8:0] top;
    logic [47:0] min2, max2;
    logic [AW-1:0] maddr;

    always_comb begin
        nbc = (r_nb == 9'd0) ? 9'd1 : r_nb;
        if (32'(nbc) > BINS) nbc = 9'(BINS);
        top = nbc - 9'd1;
    end

    // Floored division on a signed numerator: offset so the dividend is positive.
    logic signed [24:0] cur_d;
    logic [22:0] cur_b;
    always_comb begin
        cur_d = (r_st == S_DX || r_st == S_DXW) ? r_dx : r_dy;
        cur_b = (r_st == S_DX || r_st == S_DXW) ? r_bx : r_by;
        wnum = 27'(2 * 27'(cur_d)) + 27'($signed({4'd0, cur_b}));
        wden = {2'd0, cur_b, 1'b0};
        // The offset is 2^40 times the divisor, so the quotient comes out 2^40 too large.
        wnum_off = 64'($signed(wnum)) + ({24'd0, wden[25:0], 14'd0} << 26);
        wq = $signed(rsp.quo[26:0]);
    end

    always_comb begin
        min2 = 48'(r_min) * 48'(r_min);
        max2 = 48'(r_max) * 48'(r_max);
    end

    always_comb begin
        n_st = r_st;
        n_clr = r_clr;
        n_up = r_up;
        n_lp = r_lp;
        n_dx = r_dx;
        n_dy = r_dy;
        n_d2 = r_d2;
        n_ax = r_ax;
        n_rin = r_rin;
        n_bin = r_bin;
        n_ov = r_ov;
        req = '{start: 1'b0, op: OP_DIV, num: '0, den: '0};
        i_in.ready = 1'b0;
        o_out.valid = 1'b0;
        unique case (r_st)
            S_CLR: begin
                n_clr = r_clr + 1'b1;
                if (32'(r_clr) == BINS - 1) n_st = (r_cmd == CMD_CLEAR) ? S_OUT : S_IDLE;
            end
            S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_rin = 1'b0;
                    n_bin = '0;
                    n_dx = 25'(i_in.second_x) - 25'(i_in.first_x);
                    n_dy = 25'(i_in.second_y) - 25'(i_in.first_y);
                    if (i_in.command == CMD_CLEAR) begin
                        n_clr = '0;
                        n_up = '0;
                        n_lp = '0;
                        n_st = S_CLR;
                    end else if (i_in.command == CMD_READ) begin
                        n_bin = i_in.bin_index;
                        n_st = S_RD;
                    end else if (i_in.command == CMD_ACC && !i_in.same_group) begin
                        if (i_in.upper_leaflet)
                            n_up = ((r_up + 48'(i_in.weight)) < r_up) ? PMAX
                                : r_up + 48'(i_in.weight);
                        else
                            n_lp = ((r_lp + 48'(i_in.weight)) < r_lp) ? PMAX
                                : r_lp + 48'(i_in.weight);
                        n_st = S_DX;
                    end else begin
                        n_st = S_OUT;
                    end
                end
            end
            S_DX, S_DY: begin
                if (cur_b == '0) begin
                    n_st = (r_st == S_DX) ? S_DY : S_SQX;
                end else begin
                    req.start = 1'b1;
                    req.op = OP_DIV;
                    req.num = wnum_off;
                    req.den = {38'd0, wden};
                    n_st = (r_st == S_DX) ? S_DXW : S_DYW;
                end
            end
            S_DXW, S_DYW: begin
                if (rsp.done) begin
                    if (r_st == S_DXW) begin
                        n_dx = 25'(27'(r_dx) - wq * 27'($signed({1'b0, r_bx})));
                        n_st = S_DY;
                    end else begin
                        n_dy = 25'(27'(r_dy) - wq * 27'($signed({1'b0, r_by})));
                        n_st = S_SQX;
                    end
                end
            end
            S_SQX: begin
                n_ax = r_dx[24] ? 25'(-r_dx) : r_dx;
                n_st = S_SQY;
            end
            S_SQY: begin
                n_d2 = 49'(r_ax) * 49'(r_ax);
                n_ax = r_dy[24] ? 25'(-r_dy) : r_dy;
                n_st = S_CMP;
            end
            S_CMP: begin
                n_d2 = r_d2 + 49'(r_ax) * 49'(r_ax);
                n_st = S_SQ;
            end
            S_SQ: begin
                if (r_d2 < 49'(max2) && r_d2 > 49'(min2)) begin
                    req.start = 1'b1;
                    req.op = OP_SQRT;
                    req.num = 64'(r_d2);
                    n_rin = 1'b1;
                    n_st = S_SQW;
                end else begin
                    n_st = S_OUT;
                end
            end
            S_SQW: begin
                if (rsp.done) begin
                    n_ax = 25'(rsp.quo);
                    n_st = S_BIN;
                end
            end
            S_BIN: begin
                if (r_wid == '0) begin
                    n_bin = top[7:0];
                    n_st = S_RD;
                end else begin
                    req.start = 1'b1;
                    req.op = OP_DIV;
                    req.num = 64'(r_ax) - 64'(r_min);
                    req.den = 64'(r_wid);
                    n_st = S_BINW;
                end
            end
            S_BINW: begin
                if (rsp.done) begin
                    n_bin = (rsp.quo > 64'(top)) ? top[7:0] : rsp.quo[7:0];
                    n_st = S_RD;
                end
            end
            S_RD: begin
                n_ov = (32'(r_bin) >= BINS);
                n_st = r_rin ? S_UPD : S_OUT;
            end
            S_UPD: begin
                n_st = S_OUT;
            end
            S_OUT: begin
                o_out.valid = 1'b1;
                if (o_out.ready) n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    assign maddr = (r_st == S_CLR) ? r_clr[AW-1:0] : AW'(r_bin);

    logic [39:0] su, sl;
    always_comb begin
        su = ((r_mu + 40'(r_w)) < r_mu) ? HMAX : r_mu + 40'(r_w);
        sl = ((r_ml + 40'(r_w)) < r_ml) ? HMAX : r_ml + 40'(r_w);
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_CLR) begin
            mem_u[maddr] <= '0;
            mem_l[maddr] <= '0;
        end else if (r_st == S_UPD) begin
            if (r_upper) mem_u[maddr] <= su;
            else mem_l[maddr] <= sl;
        end
        r_mu <= mem_u[maddr];
        r_ml <= mem_l[maddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR;
            r_clr <= '0;
            r_cmd <= CMD_ACC;
            r_min <= '0;
            r_max <= 23'd10240;
            r_wid <= 23'd256;
            r_nb <= 9'd40;
            r_up <= '0;
            r_lp <= '0;
        end else begin
            r_st <= n_st;
            r_clr <= n_clr;
            r_up <= n_up;
            r_lp <= n_lp;
            if (r_st == S_IDLE && i_in.valid) r_cmd <= i_in.command;
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    REG_MIN: r_min <= i_cfg.data;
                    REG_MAX: r_max <= i_cfg.data;
                    REG_WIDTH: r_wid <= i_cfg.data;
                    REG_BINS: r_nb <= i_cfg.data[8:0];
                    default: ;
                endcase
            end
        end
        r_dx <= n_dx;
        r_dy <= n_dy;
        r_d2 <= n_d2;
        r_ax <= n_ax;
        r_rin <= n_rin;
        r_bin <= n_bin;
        r_ov <= n_ov;
        if (r_st == S_IDLE && i_in.valid) begin
            r_upper <= i_in.upper_leaflet;
            r_bx <= i_in.box_x;
            r_by <= i_in.box_y;
            r_w <= i_in.weight;
        end
        if (r_st == S_UPD) begin
            r_uc <= r_upper ? su : r_mu;
            r_lc <= r_upper ? r_ml : sl;
        end else if (r_st == S_RD || r_st == S_IDLE) begin
            r_uc <= '0;
            r_lc <= '0;
        end
    end

    logic rd_show;
    assign rd_show = (r_cmd == CMD_READ) && !r_ov;
    assign i_cfg.ready = 1'b1;
    assign o_out.in_range = r_rin;
    assign o_out.bin_hit = (r_cmd == CMD_ACC && !r_rin) ? 8'd0 : r_bin;
    assign o_out.upper_count = rd_show ? r_mu : r_uc;
    assign o_out.lower_count = rd_show ? r_ml : r_lc;
    assign o_out.upper_pairs = (r_cmd == CMD_NOP) ? '0 : r_up;
    assign o_out.lower_pairs = (r_cmd == CMD_NOP) ? '0 : r_lp;

    `ASSERT_IMPLIES(a_rdy_idle, i_clk, i_rst_n, i_in.ready, r_st == S_IDLE)
    `ASSERT_IMPLIES(a_excl, i_clk, i_rst_n, o_out.valid, !i_in.ready)
    `ASSERT_IMPLIES(a_rin_acc, i_clk, i_rst_n, o_out.valid && o_out.in_range, r_cmd == CMD_ACC)
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out.valid && !o_out.ready, o_out.valid)
endmodule
